/* rtl/ohpe_pkg.sv */
// ----------------------------------------------------------------------------
// ohpe_pkg
// Shared types, constants and functions of the overlapped Hann power envelope:
// register codes, controller state and command types, clamping of the window
// and period settings, and the constant (1 - cos) Hann table.
// ----------------------------------------------------------------------------
package ohpe_pkg;

    // Window table geometry.
    localparam int MAX_WINDOW      = 4096;
    localparam int LOG2_MAX_WINDOW = 12;
    localparam int HANN_BITS       = 16;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_BITS       = 4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOG2_WINDOW = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOG2_PERIOD = 4'd1;
    localparam logic [CFG_BITS-1:0] LOG2_WINDOW_RESET = 4'd10;
    localparam logic [CFG_BITS-1:0] LOG2_PERIOD_RESET = 4'd9;

    // Accumulators and result.
    localparam int ACC_BITS     = 64;
    localparam int OUT_BITS     = 47;
    localparam int M_TDATA_BITS = 48;
    localparam int SCALE_BASE   = 15;

    // Fixed-point constants for the cosine series.
    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] COS_STEP = 64'd6908435304720 / (4 * MAX_WINDOW);

    typedef logic [MAX_WINDOW-1:0][HANN_BITS-1:0] hann_rom_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;         // capture the input item
        logic square;       // square the sample, restart the slot count
        logic issue;        // start one accumulator update
        logic emit_read;    // read the oldest accumulator
        logic emit_commit;  // load the result, retire the oldest slot
        logic phase_dec;    // count the phase down without a result
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_k;       // the slot being issued is the last active one
        logic pipe_busy;    // accumulator updates still in flight
        logic phase_zero;   // this item closes a window
        logic out_full;     // output register holds an item not yet taken
    } ctrl_status_t;

    function automatic logic [CFG_BITS-1:0] eff_log2_window(input logic [CFG_BITS-1:0] raw);
        logic [CFG_BITS-1:0] lw;
        lw = raw;
        if (lw < 4'd1) begin
            lw = 4'd1;
        end
        if (lw > CFG_BITS'(LOG2_MAX_WINDOW)) begin
            lw = CFG_BITS'(LOG2_MAX_WINDOW);
        end
        return lw;
    endfunction

    function automatic logic [CFG_BITS-1:0] eff_log2_period(input logic [CFG_BITS-1:0] raw,
                                                            input logic [CFG_BITS-1:0] lw,
                                                            input logic [CFG_BITS-1:0] log2_ov);
        logic [CFG_BITS-1:0] lo;
        logic [CFG_BITS-1:0] lp;
        lo = (lw > log2_ov) ? (lw - log2_ov) : 4'd0;
        lp = raw;
        if (lp < lo) begin
            lp = lo;
        end
        if (lp > lw) begin
            lp = lw;
        end
        return lp;
    endfunction

    // Cosine over the first quadrant in Q30, from a truncated Taylor series in
    // Horner form.
    function automatic logic signed [63:0] quarter_cos(input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (k * COS_STEP + 64'd512) >> 10;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd132;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
        return $signed(Q30_ONE) - $signed(((x2 * t) >> 30) / 64'd2);
    endfunction

    // Q1.15 table of (1 - cos(2*pi*i/MAX_WINDOW)), evaluated at elaboration.
    function automatic hann_rom_t build_hann_rom();
        hann_rom_t         rom;
        logic [63:0]        m;
        logic [63:0]        j;
        logic signed [63:0] c;
        logic signed [63:0] d;
        logic signed [63:0] q;
        m = 64'(MAX_WINDOW);
        for (int i = 0; i < MAX_WINDOW; i++) begin
            j = 64'(4 * i);
            if (j <= m) begin
                c = quarter_cos(j);
            end else if (j <= 2 * m) begin
                c = -quarter_cos(2 * m - j);
            end else if (j <= 3 * m) begin
                c = -quarter_cos(j - 2 * m);
            end else begin
                c = quarter_cos(4 * m - j);
            end
            d = $signed(Q30_ONE) - c;
            if (d < 0) begin
                d = 0;
            end
            q = (d + 64'sd16384) >>> 15;
            if (q > 64'sd65535) begin
                q = 64'sd65535;
            end
            rom[i] = q[HANN_BITS-1:0];
        end
        return rom;
    endfunction

endpackage

/* rtl/overlapped_hann_power_envelope_core.sv */
// Each item makes n accumulator updates, where n = window / period (1 to
// 32); one update enters the read/multiply/add pipeline per cycle through
// the accumulator memory. Reset is synchronous and active low; afterwards
// all accumulators read as empty at once and the settings are window 1024,
// period 512.
// ----------------------------------------------------------------------------
// overlapped_hann_power_envelope_core
// Hann-weighted mean power over overlapping windows of a sample stream, one
// result per period.
// ----------------------------------------------------------------------------
module overlapped_hann_power_envelope_core #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_OVERLAP = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration writes.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ohpe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ohpe_pkg::CFG_BITS-1:0]         cfg_data,
    // Sample items.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample
    // Result items.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ohpe_pkg::M_TDATA_BITS-1:0]     m_tdata   // mean_power, zero pad
);

    ohpe_pkg::ctrl_cmd_t           cmd;
    ohpe_pkg::ctrl_status_t        status;
    logic [ohpe_pkg::OUT_BITS-1:0] mean_power;

    // The user must change settings only while the block is idle; the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    ohpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ohpe_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_OVERLAP (MAX_OVERLAP)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (s_tdata[SAMPLE_BITS-1:0]),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .mean_power (mean_power)
    );

    assign m_tdata = {{(ohpe_pkg::M_TDATA_BITS - ohpe_pkg::OUT_BITS){1'b0}}, mean_power};

`ifndef NO_ASSERTIONS
    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_commit |-> !(m_tvalid && !m_tready))
        else $error("result loaded over a pending item");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

    // A result appears only after the sequencer commits one.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.emit_commit))
        else $error("result valid without a commit");

    // The sequencer drives at most one command at a time.
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.square, cmd.issue, cmd.emit_read,
                  cmd.emit_commit, cmd.phase_dec}))
        else $error("conflicting sequencer commands");
`endif

endmodule

/* rtl/ohpe_ctrl.sv */
// ----------------------------------------------------------------------------
// ohpe_ctrl
// Sequencer: takes an item, squares it, issues one accumulator update per
// cycle, waits for the update pipeline to drain, then emits or counts down.
// ----------------------------------------------------------------------------
module ohpe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output ohpe_pkg::ctrl_cmd_t    cmd,
    input  ohpe_pkg::ctrl_status_t status
);

    ohpe_pkg::ctrl_state_t state_reg;
    ohpe_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ohpe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ohpe_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ohpe_pkg::ST_SQUARE;
                end
            end
            ohpe_pkg::ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ohpe_pkg::ST_ISSUE;
            end
            ohpe_pkg::ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (status.last_k) begin
                    state_next = ohpe_pkg::ST_DRAIN;
                end
            end
            ohpe_pkg::ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    if (status.phase_zero) begin
                        state_next = ohpe_pkg::ST_EMIT_RD;
                    end else begin
                        cmd.phase_dec = 1'b1;
                        state_next    = ohpe_pkg::ST_IDLE;
                    end
                end
            end
            ohpe_pkg::ST_EMIT_RD: begin
                cmd.emit_read = 1'b1;
                state_next    = ohpe_pkg::ST_EMIT_WAIT;
            end
            ohpe_pkg::ST_EMIT_WAIT: begin
                if (!status.out_full) begin
                    cmd.emit_commit = 1'b1;
                    state_next      = ohpe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ohpe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ohpe_datapath.sv */
// ----------------------------------------------------------------------------
// ohpe_datapath
// Settings, phase counter, squarer, Hann table, the accumulator ring with its
// three-stage read/multiply/add update pipeline, and the output register.
// ----------------------------------------------------------------------------
module ohpe_datapath #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_OVERLAP = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [ohpe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ohpe_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  ohpe_pkg::ctrl_cmd_t                    cmd,
    output ohpe_pkg::ctrl_status_t                 status,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ohpe_pkg::OUT_BITS-1:0]         mean_power
);

    localparam int LOG2_OV    = $clog2(MAX_OVERLAP + 1) - 1;
    localparam int SLOT_BITS  = (LOG2_OV > 0) ? LOG2_OV : 1;
    localparam int NSLOTS     = 1 << SLOT_BITS;
    localparam int AW         = ohpe_pkg::LOG2_MAX_WINDOW;
    localparam int CW         = ohpe_pkg::CFG_BITS;
    localparam int SQ_BITS    = 2 * SAMPLE_BITS;
    localparam int AB         = ohpe_pkg::ACC_BITS;
    localparam int PROD_FULL  = ohpe_pkg::HANN_BITS + SQ_BITS;
    localparam int PW         = (PROD_FULL > AB) ? PROD_FULL : AB;
    localparam int SH_BITS    = 5;

    localparam ohpe_pkg::hann_rom_t HANN_ROM = ohpe_pkg::build_hann_rom();

    // Settings and control state.
    logic [CW-1:0]        raw_lw_reg;
    logic [CW-1:0]        raw_lp_reg;
    logic [CW-1:0]        lw_reg;
    logic [CW-1:0]        lp_reg;
    logic [AW-1:0]        phase_reg;
    logic [SLOT_BITS-1:0] base_reg;
    logic [SLOT_BITS-1:0] k_reg;
    logic [NSLOTS-1:0]    vld_reg;
    logic                 s1_reg;
    logic                 s2_reg;
    logic                 m_tvalid_reg;

    // Payload.
    logic signed [SAMPLE_BITS-1:0]       sample_reg;
    logic [SQ_BITS-1:0]                  sq_reg;
    logic [ohpe_pkg::HANN_BITS-1:0]      coef_reg;
    logic [AB-1:0]                       acc_rd_reg;
    logic                                vld_a_reg;
    logic [SLOT_BITS-1:0]                slot_b_reg;
    logic [AB-1:0]                       prod_reg;
    logic [AB-1:0]                       acc_b_reg;
    logic [SLOT_BITS-1:0]                slot_c_reg;
    logic [ohpe_pkg::OUT_BITS-1:0]       mean_power_reg;
    logic [AB-1:0]                       acc_mem [NSLOTS];

    // Settings that a write would produce.
    logic [CW-1:0] raw_lw_next;
    logic [CW-1:0] raw_lp_next;
    logic [CW-1:0] lw_next;
    logic [CW-1:0] lp_next;
    logic [AW:0]   period_next;
    logic          cfg_hit;

    // Derived geometry.
    logic [CW-1:0]        dlog;
    logic [SLOT_BITS:0]   n_pow;
    logic [SLOT_BITS-1:0] n_mask;
    logic [AW:0]          period_pow;
    logic [AW-1:0]        phase_reload;
    logic [AW:0]          win_pow;
    logic [AW-1:0]        win_mask;
    logic [CW-1:0]        sh;
    logic [AW-1:0]        k_offset;
    logic [AW-1:0]        tap;
    logic [AW-1:0]        rom_addr;
    logic [SLOT_BITS-1:0] slot_a;
    logic [SLOT_BITS-1:0] rd_addr;

    // Arithmetic.
    logic [SAMPLE_BITS-1:0] mag;
    logic [PW-1:0]          prod_wide;
    logic [AB-1:0]          prod_sat;
    logic [AB:0]            sum_wide;
    logic [AB-1:0]          acc_new;
    logic [AB-1:0]          emit_acc;
    logic [SH_BITS-1:0]     shamt;
    logic [AB-1:0]          scaled;
    logic [ohpe_pkg::OUT_BITS-1:0] scaled_sat;

    assign cfg_hit     = cfg_we && (cfg_index == ohpe_pkg::REG_LOG2_WINDOW ||
                                    cfg_index == ohpe_pkg::REG_LOG2_PERIOD);
    assign raw_lw_next = (cfg_index == ohpe_pkg::REG_LOG2_WINDOW) ? cfg_data : raw_lw_reg;
    assign raw_lp_next = (cfg_index == ohpe_pkg::REG_LOG2_PERIOD) ? cfg_data : raw_lp_reg;
    assign lw_next     = ohpe_pkg::eff_log2_window(raw_lw_next);
    assign lp_next     = ohpe_pkg::eff_log2_period(raw_lp_next, lw_next, CW'(LOG2_OV));
    assign period_next = (AW + 1)'(1) << lp_next;

    assign dlog         = lw_reg - lp_reg;
    assign n_pow        = (SLOT_BITS + 1)'(1) << dlog;
    assign n_mask       = SLOT_BITS'(n_pow - 1'b1);
    assign period_pow   = (AW + 1)'(1) << lp_reg;
    assign phase_reload = AW'(period_pow - 1'b1);
    assign win_pow      = (AW + 1)'(1) << lw_reg;
    assign win_mask     = AW'(win_pow - 1'b1);
    assign sh           = CW'(AW) - lw_reg;

    // Slot k is k periods younger than the oldest one, so its coefficient
    // index is the phase plus k periods, taken modulo the window.
    assign k_offset = AW'(AW'(k_reg) << lp_reg);
    assign tap      = (phase_reg + k_offset) & win_mask;
    assign rom_addr = AW'(tap << sh);
    assign slot_a   = (base_reg + k_reg) & n_mask;
    assign rd_addr  = cmd.issue ? slot_a : base_reg;

    assign mag       = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign prod_wide = PW'(coef_reg) * PW'(sq_reg);
    assign prod_sat  = ((prod_wide >> AB) != '0) ? '1 : prod_wide[AB-1:0];
    assign sum_wide  = {1'b0, acc_b_reg} + {1'b0, prod_reg};
    assign acc_new   = sum_wide[AB] ? '1 : sum_wide[AB-1:0];

    assign emit_acc   = vld_a_reg ? acc_rd_reg : '0;
    assign shamt      = SH_BITS'(ohpe_pkg::SCALE_BASE) + SH_BITS'(lw_reg);
    assign scaled     = emit_acc >> shamt;
    assign scaled_sat = ((scaled >> ohpe_pkg::OUT_BITS) != '0) ? '1
                                                               : scaled[ohpe_pkg::OUT_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_lw_reg   <= ohpe_pkg::LOG2_WINDOW_RESET;
            raw_lp_reg   <= ohpe_pkg::LOG2_PERIOD_RESET;
            lw_reg       <= ohpe_pkg::eff_log2_window(ohpe_pkg::LOG2_WINDOW_RESET);
            lp_reg       <= ohpe_pkg::eff_log2_period(
                                ohpe_pkg::LOG2_PERIOD_RESET,
                                ohpe_pkg::eff_log2_window(ohpe_pkg::LOG2_WINDOW_RESET),
                                CW'(LOG2_OV));
            phase_reg    <= AW'(((AW + 1)'(1) << ohpe_pkg::eff_log2_period(
                                ohpe_pkg::LOG2_PERIOD_RESET,
                                ohpe_pkg::eff_log2_window(ohpe_pkg::LOG2_WINDOW_RESET),
                                CW'(LOG2_OV))) - 1'b1);
            base_reg     <= '0;
            k_reg        <= '0;
            vld_reg      <= '0;
            s1_reg       <= 1'b0;
            s2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            s1_reg <= cmd.issue;
            s2_reg <= s1_reg;
            if (cmd.emit_commit && !cfg_hit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_hit) begin
                // A new setting restarts every window.
                raw_lw_reg <= raw_lw_next;
                raw_lp_reg <= raw_lp_next;
                lw_reg     <= lw_next;
                lp_reg     <= lp_next;
                phase_reg  <= AW'(period_next - 1'b1);
                base_reg   <= '0;
                vld_reg    <= '0;
            end else begin
                if (cmd.square) begin
                    k_reg <= '0;
                end
                if (cmd.issue) begin
                    k_reg <= k_reg + 1'b1;
                end
                if (s2_reg) begin
                    vld_reg[slot_c_reg] <= 1'b1;
                end
                if (cmd.phase_dec) begin
                    phase_reg <= phase_reg - 1'b1;
                end
                if (cmd.emit_commit) begin
                    // The emitted slot becomes the youngest, empty window.
                    vld_reg[base_reg] <= 1'b0;
                    base_reg          <= (base_reg + 1'b1) & n_mask;
                    phase_reg         <= phase_reload;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= sample;
        end
        if (cmd.square) begin
            sq_reg <= SQ_BITS'(mag) * SQ_BITS'(mag);
        end
        if (cmd.issue) begin
            coef_reg   <= HANN_ROM[rom_addr];
            slot_b_reg <= slot_a;
        end
        if (cmd.issue || cmd.emit_read) begin
            acc_rd_reg <= acc_mem[rd_addr];
            vld_a_reg  <= vld_reg[rd_addr];
        end
        prod_reg   <= prod_sat;
        acc_b_reg  <= vld_a_reg ? acc_rd_reg : '0;
        slot_c_reg <= slot_b_reg;
        if (cmd.emit_commit) begin
            mean_power_reg <= scaled_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_reg) begin
            acc_mem[slot_c_reg] <= acc_new;
        end
    end

    assign status.last_k     = (k_reg == n_mask);
    assign status.pipe_busy  = s1_reg || s2_reg;
    assign status.phase_zero = (phase_reg == '0);
    assign status.out_full   = m_tvalid_reg && !m_tready;

    assign m_tvalid   = m_tvalid_reg;
    assign mean_power = mean_power_reg;

endmodule
